// File: src/artbs_pkg.sv
// ============================================================================
// artbs_pkg - address range table search package
// Shared widths, codes and the command/status structs between the
// controller and the datapath.
// ============================================================================
package artbs_pkg;

    localparam int DATA_W              = 64;
    localparam int IDX_OUT_W           = 7;
    localparam int STATUS_W            = 2;
    localparam int KIND_W              = 2;
    localparam int CFG_IDX_W           = 2;
    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam logic [DATA_W-1:0] WINDOW_LOW_RESET  = '0;
    localparam logic [DATA_W-1:0] WINDOW_HIGH_RESET = 64'h0000_8000_0000_0000;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_RANGE  = 2'd2,
        KIND_PLACE  = 2'd3
    } kind_t;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOMEM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 2'd1;

    // table read address relative to the scan index
    typedef enum logic [1:0] {
        ADDR_IDX,
        ADDR_INC,
        ADDR_DEC,
        ADDR_DEC2
    } addr_sel_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef struct packed {
        logic      in_ready;
        logic      update;
        addr_sel_t addr_sel;
        idx_op_t   idx_op;
        logic      save_first;
        logic      save_end;
        logic      fill_count;
        logic      top_load;
        logic      set_found;
        logic      set_nomem;
        logic      publish;
    } cmd_t;

    typedef struct packed {
        logic  in_valid;
        kind_t in_kind;
        logic  idx_at_end;
        logic  inc_at_end;
        logic  idx_zero;
        logic  idx_one;
        logic  r1_adv;
        logic  r2_adv;
        logic  fit_mem;
        logic  fit_base;
        logic  out_busy;
    } stat_t;

endpackage

// File: src/artbs_if.sv
// ============================================================================
// artbs_if - request and response channels
// Valid/ready channels carrying one request word and one response word.
// ============================================================================
interface artbs_req_if;
    logic                           valid;
    logic                           ready;
    logic [artbs_pkg::KIND_W-1:0]   kind;
    logic [artbs_pkg::DATA_W-1:0]   entry_start;
    logic [artbs_pkg::DATA_W-1:0]   entry_end;
    logic [artbs_pkg::DATA_W-1:0]   query_start;
    logic [artbs_pkg::DATA_W-1:0]   query_end;
    logic [artbs_pkg::DATA_W-1:0]   request_length;

    modport source (
        output valid, kind, entry_start, entry_end, query_start, query_end,
               request_length,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_start, entry_end, query_start, query_end,
               request_length,
        output ready
    );
endinterface

interface artbs_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [artbs_pkg::STATUS_W-1:0]   status;
    logic [artbs_pkg::IDX_OUT_W-1:0]  first_index;
    logic [artbs_pkg::IDX_OUT_W-1:0]  end_index;
    logic [artbs_pkg::DATA_W-1:0]     placed_address;
    logic [artbs_pkg::IDX_OUT_W-1:0]  region_count;

    modport source (
        output valid, status, first_index, end_index, placed_address,
               region_count,
        input  ready
    );
    modport sink (
        input  valid, status, first_index, end_index, placed_address,
               region_count,
        output ready
    );
endinterface

// File: src/artbs_ram.sv
// ============================================================================
// artbs_ram - generic single-port-write RAM
// One write port, one read port, registered read data.
// ============================================================================
module artbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/artbs_dp.sv
// ============================================================================
// artbs_dp - address range table search datapath
// Region tables, window registers, scan index, compares and result words.
// ============================================================================
module artbs_dp #(
    parameter int TABLE_DEPTH = artbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [artbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [artbs_pkg::DATA_W-1:0]      cfg_data,
    artbs_req_if.sink                         req,
    artbs_rsp_if.source                       rsp,
    input  artbs_pkg::cmd_t                   cmd,
    output artbs_pkg::stat_t                  stat
);
    import artbs_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = CW + IDX_OUT_W;

    logic [DATA_W-1:0] window_low_reg, window_high_reg;
    logic [CW-1:0]     count_reg;
    logic              out_valid_reg;

    kind_t             kind_reg;
    logic [DATA_W-1:0] entry_start_reg, entry_end_reg;
    logic [DATA_W-1:0] query_start_reg, query_end_reg, length_reg;
    logic [DATA_W-1:0] top_reg;
    logic [CW-1:0]     idx_reg, idx_next;

    logic [STATUS_W-1:0] status_res_reg;
    logic [CW-1:0]       first_res_reg, end_res_reg;
    logic [DATA_W-1:0]   placed_res_reg;

    logic [STATUS_W-1:0]  status_out_reg;
    logic [IDX_OUT_W-1:0] first_out_reg, end_out_reg, count_out_reg;
    logic [DATA_W-1:0]    placed_out_reg;

    logic [CW-1:0]     idx_inc, idx_dec, idx_dec2, addr_full;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] starts_rd, ends_rd;
    logic              accept, table_full, ram_we;
    logic [DATA_W-1:0] top_minus_len;
    logic              top_ge_len;
    logic [EXT_W-1:0]  first_ext, end_ext, count_ext;

    assign accept     = req.valid && cmd.in_ready;
    assign req.ready  = cmd.in_ready;
    assign table_full = count_reg >= CW'(TABLE_DEPTH);
    assign ram_we     = cmd.update && (kind_reg == KIND_APPEND) && !table_full;

    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign idx_dec2 = idx_reg - CW'(2);

    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_IDX:  addr_full = idx_reg;
            ADDR_INC:  addr_full = idx_inc;
            ADDR_DEC:  addr_full = idx_dec;
            ADDR_DEC2: addr_full = idx_dec2;
            default:   addr_full = idx_reg;
        endcase
    end
    assign rd_addr = addr_full[AW-1:0];

    always_comb
    begin
        unique case (cmd.idx_op)
            IDX_INC: idx_next = idx_inc;
            IDX_DEC: idx_next = idx_dec;
            default: idx_next = idx_reg;
        endcase
    end

    artbs_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_starts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (entry_start_reg),
        .raddr (rd_addr),
        .rdata (starts_rd)
    );

    artbs_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_ends (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (entry_end_reg),
        .raddr (rd_addr),
        .rdata (ends_rd)
    );

    assign top_minus_len = top_reg - length_reg;
    assign top_ge_len    = top_reg >= length_reg;

    always_comb
    begin
        stat.in_valid   = req.valid;
        stat.in_kind    = kind_t'(req.kind);
        stat.idx_at_end = idx_reg == count_reg;
        stat.inc_at_end = idx_inc == count_reg;
        stat.idx_zero   = idx_reg == '0;
        stat.idx_one    = idx_reg == CW'(1);
        stat.r1_adv     = ends_rd <= query_start_reg;
        stat.r2_adv     = starts_rd < query_end_reg;
        stat.fit_mem    = top_ge_len && (top_minus_len >= ends_rd);
        stat.fit_base   = top_ge_len && (top_minus_len >= window_low_reg);
        stat.out_busy   = out_valid_reg && !rsp.ready;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= WINDOW_LOW_RESET;
            window_high_reg <= WINDOW_HIGH_RESET;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_WINDOW_LOW)
            begin
                window_low_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_WINDOW_HIGH)
            begin
                window_high_reg <= cfg_data;
            end
            if (cmd.update && kind_reg == KIND_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (ram_we)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg        <= kind_t'(req.kind);
            entry_start_reg <= req.entry_start;
            entry_end_reg   <= req.entry_end;
            query_start_reg <= req.query_start;
            query_end_reg   <= req.query_end;
            length_reg      <= req.request_length;
            top_reg         <= window_high_reg;
            idx_reg         <= (kind_t'(req.kind) == KIND_PLACE) ? count_reg : '0;
            status_res_reg  <= STATUS_OK;
            first_res_reg   <= '0;
            end_res_reg     <= '0;
            placed_res_reg  <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.update && kind_reg == KIND_APPEND && table_full)
            begin
                status_res_reg <= STATUS_FULL;
            end
            if (cmd.top_load)
            begin
                top_reg <= starts_rd;
            end
            if (cmd.fill_count)
            begin
                first_res_reg <= count_reg;
                end_res_reg   <= count_reg;
            end
            if (cmd.save_first)
            begin
                first_res_reg <= idx_reg;
            end
            if (cmd.save_end)
            begin
                end_res_reg <= idx_next;
            end
            if (cmd.set_found)
            begin
                placed_res_reg <= top_minus_len;
            end
            if (cmd.set_nomem)
            begin
                status_res_reg <= STATUS_NOMEM;
            end
        end
    end

    assign first_ext = EXT_W'(first_res_reg);
    assign end_ext   = EXT_W'(end_res_reg);
    assign count_ext = EXT_W'(count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            status_out_reg <= status_res_reg;
            first_out_reg  <= first_ext[IDX_OUT_W-1:0];
            end_out_reg    <= end_ext[IDX_OUT_W-1:0];
            placed_out_reg <= placed_res_reg;
            count_out_reg  <= count_ext[IDX_OUT_W-1:0];
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_out_reg;
    assign rsp.first_index    = first_out_reg;
    assign rsp.end_index      = end_out_reg;
    assign rsp.placed_address = placed_out_reg;
    assign rsp.region_count   = count_out_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("region count above table depth");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || rsp.ready))
        else $error("result overwritten before it was taken");

    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (first_res_reg <= end_res_reg))
        else $error("first index past end index");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(cmd.update))
        else $error("region count moved outside an update");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !cmd.in_ready)
        else $error("request taken while a word is in progress");
`endif

endmodule

// File: src/artbs_ctrl.sv
// ============================================================================
// artbs_ctrl - address range table search controller
// Sequences table updates, the two range scans and the downward gap scan.
// ============================================================================
module artbs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  artbs_pkg::stat_t  stat,
    output artbs_pkg::cmd_t   cmd
);
    import artbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_R1_RD,
        S_R1_CMP,
        S_R2_CMP,
        S_PL_RD,
        S_PL_CMP,
        S_PL_BASE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.addr_sel = ADDR_IDX;
        cmd.idx_op   = IDX_HOLD;
        state_next   = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    unique case (stat.in_kind)
                        KIND_CLEAR,
                        KIND_APPEND: state_next = S_UPDATE;
                        KIND_RANGE:  state_next = S_R1_RD;
                        KIND_PLACE:  state_next = S_PL_RD;
                        default:     state_next = S_UPDATE;
                    endcase
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_FINISH;
            end
            S_R1_RD:
            begin
                if (stat.idx_at_end)
                begin
                    cmd.fill_count = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    state_next = S_R1_CMP;
                end
            end
            // both tables read at the same index, so the second scan can
            // test the start of the entry where the first one stops
            S_R1_CMP:
            begin
                cmd.addr_sel = ADDR_INC;
                if (stat.r1_adv)
                begin
                    cmd.idx_op = IDX_INC;
                    if (stat.inc_at_end)
                    begin
                        cmd.fill_count = 1'b1;
                        state_next     = S_FINISH;
                    end
                end
                else
                begin
                    cmd.save_first = 1'b1;
                    if (stat.r2_adv)
                    begin
                        cmd.idx_op = IDX_INC;
                        if (stat.inc_at_end)
                        begin
                            cmd.save_end = 1'b1;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_R2_CMP;
                        end
                    end
                    else
                    begin
                        cmd.save_end = 1'b1;
                        state_next   = S_FINISH;
                    end
                end
            end
            S_R2_CMP:
            begin
                cmd.addr_sel = ADDR_INC;
                if (stat.r2_adv)
                begin
                    cmd.idx_op = IDX_INC;
                    if (stat.inc_at_end)
                    begin
                        cmd.save_end = 1'b1;
                        state_next   = S_FINISH;
                    end
                end
                else
                begin
                    cmd.save_end = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_PL_RD:
            begin
                cmd.addr_sel = ADDR_DEC;
                state_next   = stat.idx_zero ? S_PL_BASE : S_PL_CMP;
            end
            S_PL_CMP:
            begin
                if (stat.fit_mem)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.top_load = 1'b1;
                    cmd.idx_op   = IDX_DEC;
                    cmd.addr_sel = ADDR_DEC2;
                    if (stat.idx_one)
                    begin
                        state_next = S_PL_BASE;
                    end
                end
            end
            S_PL_BASE:
            begin
                cmd.set_found = stat.fit_base;
                cmd.set_nomem = !stat.fit_base;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_publish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> (state_reg == S_IDLE))
        else $error("publish did not return to idle");

    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PL_CMP && cmd.idx_op == IDX_DEC) |-> !stat.idx_zero)
        else $error("gap scan stepped below entry zero");

    a_r1_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_R1_CMP || state_reg == S_R2_CMP) |-> !stat.idx_at_end)
        else $error("range scan compared past the last region");
`endif

endmodule

// File: src/address_range_table_search.sv
// ============================================================================
// address_range_table_search - sorted region table with range and gap search
// Holds up to TABLE_DEPTH regions; clear, append, range query, placement.
// ============================================================================
// One request word gives one response word. Clear and append go from the
// idle state through the update and finish states to the response. A range
// query walks the table once, one entry per cycle; a placement query walks
// the gaps downward from the window top, one entry per cycle. The walk rate
// is set by the single read port of the region RAMs. The next request is
// taken once the current one has handed its word to the output register,
// which holds it until taken.
module address_range_table_search #(
    parameter int TABLE_DEPTH = artbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [artbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [artbs_pkg::DATA_W-1:0]      cfg_data,
    artbs_req_if.sink                         req,
    artbs_rsp_if.source                       rsp
);
    import artbs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    artbs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    artbs_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: test/address_range_table_search_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// address_range_table_search_tb - self-checking bench for the region table
// Drives clear, append, range and placement words through the request
// channel, predicts every response word from a local copy of the table and
// the window registers, and compares each response field by field. The run
// steps through several window settings and three idling patterns.
// ============================================================================
module address_range_table_search_tb;

    import artbs_pkg::*;

    localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
    localparam int CLK_HALF    = 6;
    localparam int RESET_CYC   = 6;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYC    = 20;
    localparam int PHASES      = 9;
    localparam int PHASE_WORDS = 44;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] entry_start;
        logic [DATA_W-1:0] entry_end;
        logic [DATA_W-1:0] query_start;
        logic [DATA_W-1:0] query_end;
        logic [DATA_W-1:0] request_length;
    } request_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [IDX_OUT_W-1:0] first_index;
        logic [IDX_OUT_W-1:0] end_index;
        logic [DATA_W-1:0]    placed_address;
        logic [IDX_OUT_W-1:0] region_count;
    } response_word_t;

    // local copy of the region table; predicts and checks response words
    class table_search_board;
        logic [DATA_W-1:0] rgn_start [DEPTH];
        logic [DATA_W-1:0] rgn_end [DEPTH];
        int unsigned       held;
        logic [DATA_W-1:0] win_low;
        logic [DATA_W-1:0] win_high;
        response_word_t    awaited [$];
        int                fails;
        int                checked;

        function new();
            held     = 0;
            win_low  = WINDOW_LOW_RESET;
            win_high = WINDOW_HIGH_RESET;
            fails    = 0;
            checked  = 0;
        endfunction

        function void set_window(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
            win_low  = lo;
            win_high = hi;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void note_request(request_word_t w);
            response_word_t    e;
            int unsigned       n;
            int unsigned       l;
            int unsigned       h;
            int unsigned       k;
            logic [DATA_W-1:0] top;
            logic [DATA_W-1:0] bottom;
            bit                found;
            bit                done;
            e        = '0;
            e.status = STATUS_OK;
            n        = (held > DEPTH) ? DEPTH : held;
            case (w.kind)
                KIND_CLEAR:
                    held = 0;
                KIND_APPEND:
                begin
                    if (n >= DEPTH)
                        e.status = STATUS_FULL;
                    else
                    begin
                        rgn_start[n] = w.entry_start;
                        rgn_end[n]   = w.entry_end;
                        held         = n + 1;
                    end
                end
                KIND_RANGE:
                begin
                    l = 0;
                    while (l < n && rgn_end[l] <= w.query_start)
                        l++;
                    h = l;
                    while (h < n && rgn_start[h] < w.query_end)
                        h++;
                    e.first_index = IDX_OUT_W'(l);
                    e.end_index   = IDX_OUT_W'(h);
                end
                KIND_PLACE:
                begin
                    // walk the gaps from the window top downward
                    top   = win_high;
                    k     = n;
                    found = 1'b0;
                    done  = 1'b0;
                    while (!done)
                    begin
                        if (k == 0)
                            bottom = win_low;
                        else
                            bottom = rgn_end[k - 1];
                        if (top >= w.request_length && top - w.request_length >= bottom)
                        begin
                            e.placed_address = top - w.request_length;
                            found            = 1'b1;
                            done             = 1'b1;
                        end
                        else if (k == 0)
                            done = 1'b1;
                        else
                        begin
                            top = rgn_start[k - 1];
                            k--;
                        end
                    end
                    if (!found)
                        e.status = STATUS_NOMEM;
                end
            endcase
            e.region_count = IDX_OUT_W'((held > DEPTH) ? DEPTH : held);
            awaited.push_back(e);
        endfunction

        task report(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            $display("mismatch at response word %0d: %s got %h want %h",
                     checked, field, got, want);
            fails++;
        endtask

        task check_response(response_word_t got);
            response_word_t want;
            if (awaited.size() == 0)
            begin
                report("word with nothing awaited, placed_address", got.placed_address, '0);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.first_index !== want.first_index)
                report("first_index", got.first_index, want.first_index);
            if (got.end_index !== want.end_index)
                report("end_index", got.end_index, want.end_index);
            if (got.placed_address !== want.placed_address)
                report("placed_address", got.placed_address, want.placed_address);
            if (got.region_count !== want.region_count)
                report("region_count", got.region_count, want.region_count);
            checked++;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    artbs_req_if req ();
    artbs_rsp_if rsp ();

    table_search_board board;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles = 0;
    int sent_words   = 0;

    address_range_table_search #(
        .TABLE_DEPTH (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // response side: random back-pressure, every taken word checked
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            board.check_response({rsp.status, rsp.first_index, rsp.end_index,
                                  rsp.placed_address, rsp.region_count});
        rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog on cycles with no word taken on either channel
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [DATA_W-1:0] rand_scaled();
        return rand64() >> $urandom_range(0, DATA_W - 1);
    endfunction

    function automatic request_word_t random_word();
        request_word_t w;
        w.kind           = kind_t'($urandom_range(0, 3));
        w.entry_start    = rand64();
        w.entry_end      = rand64();
        w.query_start    = rand64();
        w.query_end      = rand64();
        w.request_length = rand64();
        return w;
    endfunction

    // an address near a region boundary, a random one, or an extreme
    function automatic logic [DATA_W-1:0] table_point();
        int unsigned       n;
        int unsigned       i;
        logic [DATA_W-1:0] p;
        n = board.held;
        p = rand_scaled();
        if (n != 0)
        begin
            i = $urandom_range(0, n - 1);
            case ($urandom_range(0, 7))
                0: p = board.rgn_start[i];
                1: p = board.rgn_end[i];
                2: p = board.rgn_start[i] - 1;
                3: p = board.rgn_end[i] - 1;
                4: p = board.rgn_start[i] + 1;
                5: p = board.rgn_end[i] + 1;
                default: ;
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            p = ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
        return p;
    endfunction

    // a length close to the size of one of the current gaps, or zero, one, a random length or all ones
    function automatic logic [DATA_W-1:0] hole_length();
        int unsigned       n;
        int unsigned       k;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] bottom;
        logic [DATA_W-1:0] g;
        n = board.held;
        k = $urandom_range(0, n);
        if (k == n)
            top = board.win_high;
        else
            top = board.rgn_start[k];
        if (k == 0)
            bottom = board.win_low;
        else
            bottom = board.rgn_end[k - 1];
        g = top - bottom;
        case ($urandom_range(0, 7))
            2: g = g + 1;
            3: g = g - 1;
            4: g = '0;
            5: g = 1;
            6: g = rand_scaled();
            7: g = ALL_ONES;
            default: ;
        endcase
        return g;
    endfunction

    task automatic send_word(input request_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid          <= 1'b1;
        req.kind           <= w.kind;
        req.entry_start    <= w.entry_start;
        req.entry_end      <= w.entry_end;
        req.query_start    <= w.query_start;
        req.query_end      <= w.query_end;
        req.request_length <= w.request_length;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(w);
        sent_words++;
    endtask

    task automatic send_item(input kind_t k, input logic [DATA_W-1:0] a,
                             input logic [DATA_W-1:0] b);
        request_word_t w;
        w      = '0;
        w.kind = k;
        case (k)
            KIND_APPEND:
            begin
                w.entry_start = a;
                w.entry_end   = b;
            end
            KIND_RANGE:
            begin
                w.query_start = a;
                w.query_end   = b;
            end
            KIND_PLACE:
                w.request_length = a;
            default: ;
        endcase
        send_word(w);
    endtask

    // hold the request side until every awaited word has come back
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_window(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WINDOW_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_WINDOW_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_window(lo, hi);
    endtask

    // clear, a run of sorted disjoint appends, then queries against them
    task automatic run_sequence(input bit fill);
        int unsigned       m;
        int unsigned       mm;
        int unsigned       q;
        int unsigned       i;
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] stride;
        logic [DATA_W-1:0] cursor;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] qs;
        logic [DATA_W-1:0] qe;
        request_word_t     w;
        w      = random_word();
        w.kind = KIND_CLEAR;
        send_word(w);
        if (fill)
            m = DEPTH + $urandom_range(1, 3);
        else if ($urandom_range(0, 3) == 0)
            m = $urandom_range(0, 2);
        else
            m = $urandom_range(1, 10);
        mm = (m > DEPTH) ? DEPTH : m;
        if (board.win_high > board.win_low)
            span = board.win_high - board.win_low;
        else
            span = rand_scaled();
        stride = span / (2 * mm + 2);
        cursor = board.win_low;
        for (i = 0; i < m; i++)
        begin
            w      = random_word();
            w.kind = KIND_APPEND;
            if ($urandom_range(0, 3) == 0)
                s = cursor;
            else
                s = cursor + rand64() % (stride + 1);
            cursor        = s + 1 + rand64() % (stride + 1);
            w.entry_start = s;
            w.entry_end   = cursor;
            send_word(w);
        end
        q = $urandom_range(2, 10);
        for (i = 0; i < q; i++)
        begin
            w = random_word();
            if ($urandom_range(0, 1) != 0)
            begin
                w.kind = KIND_RANGE;
                qs     = table_point();
                qe     = table_point();
                if ($urandom_range(0, 3) != 0 && qe < qs)
                begin
                    w.query_start = qe;
                    w.query_end   = qs;
                end
                else
                begin
                    w.query_start = qs;
                    w.query_end   = qe;
                end
            end
            else
            begin
                w.kind           = KIND_PLACE;
                w.request_length = hole_length();
            end
            send_word(w);
        end
    endtask

    initial
    begin
        int                phase;
        int                target;
        int                seq;
        int                i;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] t;
        request_word_t     w;

        board = new();
        req.valid          <= 1'b0;
        req.kind           <= '0;
        req.entry_start    <= '0;
        req.entry_end      <= '0;
        req.query_start    <= '0;
        req.query_end      <= '0;
        req.request_length <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        rst_n              <= 1'b0;
        send_idle_pct = 11;
        recv_idle_pct = 61;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words on the reset window
        send_item(KIND_RANGE, '0, ALL_ONES);
        send_item(KIND_PLACE, '0, '0);
        send_item(KIND_PLACE, WINDOW_HIGH_RESET, '0);
        send_item(KIND_PLACE, WINDOW_HIGH_RESET + 1, '0);
        send_item(KIND_PLACE, ALL_ONES, '0);
        send_item(KIND_APPEND, 64'h1000, 64'h2000);
        send_item(KIND_APPEND, 64'h3000, 64'h4000);
        send_item(KIND_APPEND, 64'h8000, 64'h7FFF_FFFF_F000);
        send_item(KIND_RANGE, 64'h1000, 64'h2000);
        send_item(KIND_RANGE, 64'h2500, 64'h2500);
        send_item(KIND_RANGE, 64'h3800, 64'h1000);
        send_item(KIND_PLACE, '0, '0);
        send_item(KIND_PLACE, 64'h1000, '0);
        send_item(KIND_PLACE, 64'h2000, '0);
        send_item(KIND_PLACE, 64'h5000, '0);
        // unsorted and overlapping appends are stored as given
        send_item(KIND_APPEND, ALL_ONES, '0);
        send_item(KIND_APPEND, '0, ALL_ONES);
        send_item(KIND_RANGE, '0, ALL_ONES);
        send_item(KIND_RANGE, ALL_ONES, ALL_ONES);
        send_item(KIND_PLACE, 1, '0);
        send_item(KIND_PLACE, '0, '0);
        send_item(KIND_CLEAR, '0, '0);
        send_item(KIND_PLACE, 1, '0);
        send_item(KIND_RANGE, ALL_ONES, '0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    lo = WINDOW_LOW_RESET;
                    hi = WINDOW_HIGH_RESET;
                end
                1:
                begin
                    lo = '0;
                    hi = ALL_ONES;
                end
                2:
                begin
                    lo = 64'h1_0000;
                    hi = 64'h2_0000;
                end
                3:
                begin
                    lo = rand_scaled();
                    hi = rand_scaled();
                    if (hi < lo)
                    begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                end
                4:
                begin
                    lo = ALL_ONES;
                    hi = ALL_ONES;
                end
                5:
                begin
                    lo = '0;
                    hi = '0;
                end
                6:
                begin
                    // inverted window
                    lo = 64'h8000_0000_0000_0000;
                    hi = 64'h0000_0100_0000_0000;
                end
                7:
                begin
                    lo = ALL_ONES - 64'hF_FFFF;
                    hi = ALL_ONES;
                end
                default:
                begin
                    lo = rand64();
                    hi = rand64();
                end
            endcase
            write_window(lo, hi);
            if (phase < 3)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 61;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            target = sent_words + PHASE_WORDS;
            seq    = 0;
            while (sent_words < target)
            begin
                if ($urandom_range(0, 99) < 75)
                    run_sequence((seq == 0 && (phase == 0 || phase == PHASES - 1))
                                 || $urandom_range(0, 29) == 0);
                else
                begin
                    for (i = $urandom_range(1, 4); i > 0; i--)
                    begin
                        w = random_word();
                        if ($urandom_range(0, 1) != 0)
                        begin
                            w.query_start    = table_point();
                            w.query_end      = table_point();
                            w.request_length = hole_length();
                        end
                        send_word(w);
                    end
                end
                if ($urandom_range(0, 9) == 0)
                    drain();
                seq++;
            end
        end

        drain();
        repeat (TAIL_CYC) @(posedge clk);
        if (board.fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
src/artbs_pkg.sv
src/artbs_if.sv
src/artbs_ram.sv
src/artbs_dp.sv
src/artbs_ctrl.sv
src/address_range_table_search.sv
test/address_range_table_search_tb.sv
